// ----- hdl/scba_pkg.sv -----
`default_nettype none

package scba_pkg;

   localparam int CLASSES_DEF = 8;
   localparam int BLOCKS_DEF  = 64;
   localparam int NUM_LIMITS  = 8;
   localparam int LIMIT_W     = 16;
   localparam int SIZE_W      = 16;
   localparam int FCLASS_W    = 4;
   localparam int BLK_W       = 6;
   localparam int CLASS_W     = 3;
   localparam int STATUS_W    = 3;
   localparam int OP_W        = 2;
   localparam int PADDR_W     = 5;
   localparam int PDATA_W     = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_POOL  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd5;

   localparam logic [OP_W-1:0] OP_DONE = 2'd0;
   localparam logic [OP_W-1:0] OP_POP  = 2'd1;
   localparam logic [OP_W-1:0] OP_PUSH = 2'd2;

   typedef logic [LIMIT_W-1:0] limit_type;

   localparam limit_type LIMIT_RESET [NUM_LIMITS] = '{
      16'd32, 16'd64, 16'd128, 16'd256, 16'd512, 16'd1024, 16'd2048, 16'd4096
   };

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [STATUS_W-1:0] status;
      logic [CLASS_W-1:0]  cls;
      logic [BLK_W-1:0]    blk;
   } job_type;

endpackage

`default_nettype wire

// ----- hdl/scba_front.sv -----
`default_nettype none

module scba_front
   import scba_pkg::*;
#(
   parameter int CLASSES = CLASSES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [PADDR_W-1:0]  paddr,
   input  wire logic [PDATA_W-1:0]  pwdata,
   output logic      [PDATA_W-1:0]  prdata,
   output logic                     pready,
   input  wire logic                req_cmd,
   input  wire logic [SIZE_W-1:0]   req_request_size,
   input  wire logic [FCLASS_W-1:0] req_free_class,
   input  wire logic [BLK_W-1:0]    req_free_block,
   output job_type                  job
);

   localparam int IDX_W = $clog2(NUM_LIMITS);

   limit_type          limit_ff [NUM_LIMITS];
   limit_type          limit_in [NUM_LIMITS];
   logic [IDX_W-1:0]   reg_idx;
   logic               cfg_wr;
   logic               found;
   logic [CLASS_W-1:0] sel;

   assign reg_idx = paddr[IDX_W+1:2];
   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite && pready;
   assign prdata  = PDATA_W'(limit_ff[reg_idx]);

   always_comb begin
      limit_in = limit_ff;
      if (cfg_wr) begin
         limit_in[reg_idx] = pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   always_comb begin
      found = 1'b0;
      sel   = '0;
      for (int c = 0; c < CLASSES; c++) begin
         if (!found && (limit_ff[c] >= req_request_size)) begin
            found = 1'b1;
            sel   = CLASS_W'(c);
         end
      end
   end

   always_comb begin
      job.op     = OP_DONE;
      job.status = ST_OK;
      job.cls    = '0;
      job.blk    = '0;
      if (req_cmd == CMD_ALLOC) begin
         if (req_request_size == '0) begin
            job.status = ST_ZERO;
         end else if (!found) begin
            job.status = ST_TOO_LARGE;
         end else begin
            job.op  = OP_POP;
            job.cls = sel;
         end
      end else begin
         if (req_free_class >= FCLASS_W'(CLASSES)) begin
            job.status = ST_NOT_POOL;
         end else begin
            job.op  = OP_PUSH;
            job.cls = req_free_class[CLASS_W-1:0];
            job.blk = req_free_block;
         end
      end
   end

endmodule

`default_nettype wire

// ----- hdl/scba_queue.sv -----
`default_nettype none

module scba_queue
   import scba_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_en,
   input  job_type      wr_data,
   output logic         full,
   input  wire logic    rd_en,
   output job_type      rd_data,
   output logic         valid
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wptr_ff;
   logic [PTR_W-1:0]   wptr_in;
   logic [PTR_W-1:0]   rptr_ff;
   logic [PTR_W-1:0]   rptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_wr;
   logic               do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign valid   = (count_ff != '0);
   assign rd_data = slot_ff[rptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && valid;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_rd) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/scba_back.sv -----
`default_nettype none

module scba_back
   import scba_pkg::*;
#(
   parameter int CLASSES = CLASSES_DEF,
   parameter int BLOCKS  = BLOCKS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 job_valid,
   input  job_type                   job,
   output logic                      job_take,
   input  wire logic                 pop,
   output logic                      empty,
   output logic      [STATUS_W-1:0]  rsp_status,
   output logic      [CLASS_W-1:0]   rsp_granted_class,
   output logic      [BLK_W-1:0]     rsp_granted_block
);

   localparam int POS_W   = $clog2(BLOCKS);
   localparam int CNT_W   = $clog2(BLOCKS + 1);
   localparam int CIDX_W  = (CLASSES > 1) ? $clog2(CLASSES) : 1;
   localparam int MDEPTH  = CLASSES * (2 ** POS_W);
   localparam int MADDR_W = $clog2(MDEPTH);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic [BLK_W-1:0]    stack_mem_ff [MDEPTH];
   logic [BLK_W-1:0]    rd_data_ff;
   logic [CNT_W-1:0]    cnt_ff [CLASSES];
   logic [CNT_W-1:0]    cnt_in [CLASSES];
   logic [CNT_W-1:0]    low_ff [CLASSES];
   logic [CNT_W-1:0]    low_in [CLASSES];
   logic                state_ff;
   logic                state_in;
   logic                out_valid_ff;
   logic                out_valid_in;
   logic [STATUS_W-1:0] out_status_ff;
   logic [STATUS_W-1:0] out_status_in;
   logic [CLASS_W-1:0]  out_cls_ff;
   logic [CLASS_W-1:0]  out_cls_in;
   logic [BLK_W-1:0]    out_blk_ff;
   logic [BLK_W-1:0]    out_blk_in;
   logic [CLASS_W-1:0]  pend_cls_ff;
   logic [CLASS_W-1:0]  pend_cls_in;
   logic [POS_W-1:0]    pend_pos_ff;
   logic [POS_W-1:0]    pend_pos_in;
   logic                fallback_ff;
   logic                fallback_in;
   logic [CIDX_W-1:0]   cidx;
   logic [CNT_W-1:0]    cur_cnt;
   logic [CNT_W-1:0]    cur_low;
   logic [CNT_W-1:0]    pos;
   logic                out_free;
   logic                mem_rd;
   logic                mem_wr;
   logic [MADDR_W-1:0]  addr;

   assign cidx     = job.cls[CIDX_W-1:0];
   assign cur_cnt  = cnt_ff[cidx];
   assign cur_low  = low_ff[cidx];
   assign pos      = cur_cnt - 1'b1;
   assign out_free = !out_valid_ff || pop;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      low_in        = low_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_cls_in    = out_cls_ff;
      out_blk_in    = out_blk_ff;
      pend_cls_in   = pend_cls_ff;
      pend_pos_in   = pend_pos_ff;
      fallback_in   = fallback_ff;
      job_take      = 1'b0;
      mem_rd        = 1'b0;
      mem_wr        = 1'b0;
      addr          = '0;
      if (pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (job_valid && out_free) begin
               job_take      = 1'b1;
               out_status_in = job.status;
               out_cls_in    = '0;
               out_blk_in    = '0;
               case (job.op)
                  OP_POP: begin
                     if (cur_cnt == '0) begin
                        out_valid_in  = 1'b1;
                        out_status_in = ST_EXHAUSTED;
                     end else begin
                        mem_rd       = 1'b1;
                        addr         = MADDR_W'({job.cls, pos[POS_W-1:0]});
                        cnt_in[cidx] = pos;
                        fallback_in  = (pos < cur_low);
                        if (pos < cur_low) begin
                           low_in[cidx] = pos;
                        end
                        pend_cls_in = job.cls;
                        pend_pos_in = pos[POS_W-1:0];
                        state_in    = S_READ;
                     end
                  end
                  OP_PUSH: begin
                     out_valid_in = 1'b1;
                     if (cur_cnt == CNT_W'(BLOCKS)) begin
                        out_status_in = ST_OVERFLOW;
                     end else begin
                        mem_wr        = 1'b1;
                        addr          = MADDR_W'({job.cls, cur_cnt[POS_W-1:0]});
                        cnt_in[cidx]  = cur_cnt + 1'b1;
                        out_status_in = ST_OK;
                     end
                  end
                  default: begin
                     out_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = ST_OK;
               out_cls_in    = pend_cls_ff;
               out_blk_in    = fallback_ff ? BLK_W'(pend_pos_ff) : rd_data_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         for (int c = 0; c < CLASSES; c++) begin
            cnt_ff[c] <= CNT_W'(BLOCKS);
            low_ff[c] <= CNT_W'(BLOCKS);
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
         low_ff       <= low_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_cls_ff    <= out_cls_in;
      out_blk_ff    <= out_blk_in;
      pend_cls_ff   <= pend_cls_in;
      pend_pos_ff   <= pend_pos_in;
      fallback_ff   <= fallback_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         stack_mem_ff[addr] <= job.blk;
      end
      if (mem_rd) begin
         rd_data_ff <= stack_mem_ff[addr];
      end
   end

   assign empty             = !out_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_granted_class = out_cls_ff;
   assign rsp_granted_block = out_blk_ff;

endmodule

`default_nettype wire

// ----- hdl/size_class_block_allocator_core.sv -----
// Segregated-fit block allocator with up to eight size classes, each holding a
// last-in-first-out stack of free block indices. Requests enter through a queue-like
// port (push/full) and are classified at once against the class limits, so the limit
// registers must only be written while the block is idle. Classified transactions wait
// in a two-entry queue for the stack engine, which retires a rejected request or a free
// from its idle state, while a successful allocate moves to a read state for the
// registered stack memory read; no transaction is taken in that state or while an
// unread result holds the output register. Results leave through an output register
// read by empty/pop. After reset every stack is full with index 0 at the bottom;
// entries that have never been written are served from a per-class low-water mark,
// so no clearing pass is needed: requests are taken from the first cycle after reset.

`default_nettype none

module size_class_block_allocator_core
   import scba_pkg::*;
#(
   parameter int CLASSES          = CLASSES_DEF,
   parameter int BLOCKS_PER_CLASS = BLOCKS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [PADDR_W-1:0]  paddr,
   input  wire logic [PDATA_W-1:0]  pwdata,
   output logic      [PDATA_W-1:0]  prdata,
   output logic                     pready,
   input  wire logic                push,
   output logic                     full,
   input  wire logic                req_cmd,
   input  wire logic [SIZE_W-1:0]   req_request_size,
   input  wire logic [FCLASS_W-1:0] req_free_class,
   input  wire logic [BLK_W-1:0]    req_free_block,
   output logic                     empty,
   input  wire logic                pop,
   output logic      [STATUS_W-1:0] rsp_status,
   output logic      [CLASS_W-1:0]  rsp_granted_class,
   output logic      [BLK_W-1:0]    rsp_granted_block
);

   job_type front_job;
   job_type back_job;
   logic    back_valid;
   logic    back_take;

   scba_front #(
      .CLASSES (CLASSES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .req_cmd          (req_cmd),
      .req_request_size (req_request_size),
      .req_free_class   (req_free_class),
      .req_free_block   (req_free_block),
      .job              (front_job)
   );

   scba_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (front_job),
      .full    (full),
      .rd_en   (back_take),
      .rd_data (back_job),
      .valid   (back_valid)
   );

   scba_back #(
      .CLASSES (CLASSES),
      .BLOCKS  (BLOCKS_PER_CLASS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (back_valid),
      .job               (back_job),
      .job_take          (back_take),
      .pop               (pop),
      .empty             (empty),
      .rsp_status        (rsp_status),
      .rsp_granted_class (rsp_granted_class),
      .rsp_granted_block (rsp_granted_block)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("Result waiting directly after reset.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_status <= ST_OVERFLOW))
      else $error("Result carries an undefined status code.");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_status != ST_OK)) |->
         ((rsp_granted_class == '0) && (rsp_granted_block == '0)))
      else $error("Rejected transaction carries a grant.");

   a_no_take_stalled: assert property (@(posedge clock) disable iff (reset)
      (back_take && !empty && !pop) |-> 1'b0)
      else $error("Stack engine took a transaction with no room for its result.");

endmodule

`default_nettype wire
